### hw/rtl/platform_power_sequencer_assert.svh
// Assertion helpers for the power sequencer. Both sample on clock and are
// disabled while reset is high.
`ifndef PLATFORM_POWER_SEQUENCER_ASSERT_SVH
`define PLATFORM_POWER_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define PPS_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("power sequencer check failed");

// Next-cycle implication.
`define PPS_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("power sequencer check failed");

`endif

### hw/rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

   localparam int unsigned COUNT_WIDTH      = 16;
   localparam int unsigned TICKS_PER_SECOND = 1000;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam int unsigned SUB_W   = 4;
   localparam int unsigned RAIL_W  = 12;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned HOOK_W  = 3;
   localparam int unsigned CSR_IW  = 2;
   localparam int unsigned CSR_DW  = 16;

   // fixed delays of the rail sequences, in ticks
   localparam int unsigned DLY_5  = 5;
   localparam int unsigned DLY_10 = 10;
   localparam int unsigned DLY_20 = 20;
   localparam int unsigned DLY_30 = 30;
   localparam int unsigned DLY_50 = 50;

   localparam logic [7:0]  BOOT_WAIT_DEFAULT = 8'd9;
   localparam logic [15:0] PG_TIMEOUT_DEFAULT = 16'd100;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_BOOT_WAIT  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_S5_WAIT    = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_PG_TIMEOUT = 2'd2;

   // rail bits
   localparam logic [RAIL_W-1:0] R_SUSP      = 12'h001;
   localparam logic [RAIL_W-1:0] R_VCCST     = 12'h002;
   localparam logic [RAIL_W-1:0] R_VRON      = 12'h004;
   localparam logic [RAIL_W-1:0] R_PCHPWROK  = 12'h008;
   localparam logic [RAIL_W-1:0] R_SYSPWROK  = 12'h010;
   localparam logic [RAIL_W-1:0] R_SYSON     = 12'h020;
   localparam logic [RAIL_W-1:0] R_RSMRST    = 12'h040;
   localparam logic [RAIL_W-1:0] R_DPWROK    = 12'h080;
   localparam logic [RAIL_W-1:0] R_PWRBTN    = 12'h100;
   localparam logic [RAIL_W-1:0] R_AC        = 12'h200;
   localparam logic [RAIL_W-1:0] R_PCHEN     = 12'h400;
   localparam logic [RAIL_W-1:0] R_PROCHOT   = 12'h800;
   localparam logic [RAIL_W-1:0] R_G3_MASK   = 12'h3FF;

   // external state codes
   localparam logic [CODE_W-1:0] PS_G3   = 4'd0;
   localparam logic [CODE_W-1:0] PS_G3S5 = 4'd1;
   localparam logic [CODE_W-1:0] PS_S5   = 4'd2;
   localparam logic [CODE_W-1:0] PS_S5S3 = 4'd3;
   localparam logic [CODE_W-1:0] PS_S3   = 4'd4;
   localparam logic [CODE_W-1:0] PS_S3S0 = 4'd5;
   localparam logic [CODE_W-1:0] PS_S0   = 4'd6;
   localparam logic [CODE_W-1:0] PS_S0S3 = 4'd7;
   localparam logic [CODE_W-1:0] PS_S3S5 = 4'd8;
   localparam logic [CODE_W-1:0] PS_S5G3 = 4'd9;

   // hook events
   localparam logic [HOOK_W-1:0] HK_NONE     = 3'd0;
   localparam logic [HOOK_W-1:0] HK_STARTUP  = 3'd1;
   localparam logic [HOOK_W-1:0] HK_RESUME   = 3'd2;
   localparam logic [HOOK_W-1:0] HK_SUSPEND  = 3'd3;
   localparam logic [HOOK_W-1:0] HK_SHUTDOWN = 3'd4;

   typedef enum logic [9:0] {
      ST_G3   = 10'b00_0000_0001,
      ST_G3S5 = 10'b00_0000_0010,
      ST_S5   = 10'b00_0000_0100,
      ST_S5S3 = 10'b00_0000_1000,
      ST_S3   = 10'b00_0001_0000,
      ST_S3S0 = 10'b00_0010_0000,
      ST_S0   = 10'b00_0100_0000,
      ST_S0S3 = 10'b00_1000_0000,
      ST_S3S5 = 10'b01_0000_0000,
      ST_S5G3 = 10'b10_0000_0000
   } pwr_state_type;

   typedef struct packed {
      logic boot_wait_restore;
   } csr_ctl_type;

   typedef struct packed {
      logic [7:0]  boot_wait_seconds;
      logic        s5_wait_always;
      logic [15:0] pg_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic slp_s3_released;
      logic slp_s4_released;
      logic slp_sus_released;
      logic good_3v5v;
      logic good_aux_vr;
      logic good_core_vr;
      logic power_on_request;
      logic force_off_request;
      logic espi_reset_seen;
      logic throttle_request;
   } req_type;

   typedef struct packed {
      pwr_state_type          state;
      logic [SUB_W-1:0]       sub_step;
      logic [COUNT_WIDTH-1:0] wait_count;
      logic [7:0]             s5_tries;
      logic                   s5_power_up;
      logic                   forcing_off;
      logic                   custom_forcing_off;
      logic [RAIL_W-1:0]      rails;
   } seq_state_type;

   typedef struct packed {
      logic [CODE_W-1:0] acpi_state;
      logic [RAIL_W-1:0] rail_drive;
      logic [HOOK_W-1:0] hook_event;
      logic              release_button;
      logic              led_off;
      logic              sequence_failed;
   } rsp_type;

   function automatic logic [CODE_W-1:0] state_code(input pwr_state_type s);
      logic [CODE_W-1:0] c;
      unique case (s)
         ST_G3:   c = PS_G3;
         ST_G3S5: c = PS_G3S5;
         ST_S5:   c = PS_S5;
         ST_S5S3: c = PS_S5S3;
         ST_S3:   c = PS_S3;
         ST_S3S0: c = PS_S3S0;
         ST_S0:   c = PS_S0;
         ST_S0S3: c = PS_S0S3;
         ST_S3S5: c = PS_S3S5;
         ST_S5G3: c = PS_S5G3;
         default: c = PS_G3;
      endcase
      return c;
   endfunction

   function automatic logic state_is_off(input pwr_state_type s);
      return (s == ST_G3) || (s == ST_G3S5) || (s == ST_S5) || (s == ST_S5G3);
   endfunction

   // counter has reached n ticks, or saturated
   function automatic logic delay_hit(input logic [COUNT_WIDTH-1:0] cnt,
                                      input int unsigned n);
      return (32'(cnt) >= n) || (cnt == COUNT_MAX);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/pps_csr.sv
`default_nettype none

module pps_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write,
   input  wire logic [pps_pkg::CSR_IW-1:0]  csr_index,
   input  wire logic [pps_pkg::CSR_DW-1:0]  csr_data,
   input  wire pps_pkg::csr_ctl_type        ctl,
   output pps_pkg::cfg_type                 cfg
);
   import pps_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BOOT_WAIT:  cfg_in.boot_wait_seconds = csr_data[7:0];
            CSR_S5_WAIT:    cfg_in.s5_wait_always    = csr_data[0];
            CSR_PG_TIMEOUT: cfg_in.pg_timeout_ms     = csr_data[15:0];
            default: ;
         endcase
      end
      // retry give-up restores the boot wait defaults
      if (ctl.boot_wait_restore) begin
         cfg_in.boot_wait_seconds = BOOT_WAIT_DEFAULT;
         cfg_in.s5_wait_always    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boot_wait_seconds <= BOOT_WAIT_DEFAULT;
         cfg_ff.s5_wait_always    <= 1'b0;
         cfg_ff.pg_timeout_ms     <= PG_TIMEOUT_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/pps_step.sv
`default_nettype none

module pps_step (
   input  wire pps_pkg::seq_state_type  cur,
   input  wire pps_pkg::cfg_type        cfg,
   input  wire pps_pkg::req_type        req,
   output pps_pkg::seq_state_type       nxt,
   output pps_pkg::rsp_type             res,
   output pps_pkg::csr_ctl_type         ctl
);
   import pps_pkg::*;

   logic [COUNT_WIDTH-1:0] wc_inc;
   logic                   pg_fail;
   logic                   sec_hit;
   logic [8:0]             try_next;
   logic                   give_up;
   int unsigned            g3s5_lim;
   int unsigned            s3s0_lim;
   logic                   g3s5_hit;
   logic                   s3s0_hit;
   logic [SUB_W-1:0]       sub_inc;
   logic [HOOK_W-1:0]      hook;
   logic                   rel;
   logic                   led;
   logic                   fail;

   assign wc_inc   = (cur.wait_count == COUNT_MAX) ? cur.wait_count
                                                   : cur.wait_count + 1'b1;
   assign pg_fail  = delay_hit(wc_inc, 32'(cfg.pg_timeout_ms));
   assign sec_hit  = delay_hit(wc_inc, TICKS_PER_SECOND);
   assign try_next = {1'b0, cur.s5_tries} + 9'd1;
   assign give_up  = try_next > {1'b0, cfg.boot_wait_seconds};
   assign sub_inc  = cur.sub_step + 1'b1;

   // delay of the fixed-wait sub-steps
   always_comb begin
      case (cur.sub_step) inside
         4'd1, 4'd5: g3s5_lim = DLY_5;
         4'd3:       g3s5_lim = DLY_10;
         4'd4:       g3s5_lim = DLY_30;
         4'd7:       g3s5_lim = DLY_20;
         4'd8:       g3s5_lim = DLY_50;
         default:    g3s5_lim = DLY_5;
      endcase
      case (cur.sub_step)
         4'd2:    s3s0_lim = DLY_30;
         default: s3s0_lim = DLY_10;
      endcase
   end

   assign g3s5_hit = delay_hit(wc_inc, g3s5_lim);
   assign s3s0_hit = delay_hit(wc_inc, s3s0_lim);

   always_comb begin
      nxt  = cur;
      hook = HK_NONE;
      rel  = 1'b0;
      led  = 1'b0;
      fail = 1'b0;
      ctl.boot_wait_restore = 1'b0;

      // requests, against the state at tick start
      if (req.force_off_request && !state_is_off(cur.state)) begin
         nxt.forcing_off        = 1'b1;
         nxt.custom_forcing_off = 1'b1;
         nxt.rails              = nxt.rails & ~R_G3_MASK;
      end
      if (req.espi_reset_seen && req.slp_sus_released && nxt.forcing_off) begin
         rel             = 1'b1;
         nxt.forcing_off = 1'b0;
      end
      if (cur.state == ST_S0) begin
         if (req.throttle_request) nxt.rails = nxt.rails & ~R_PROCHOT;
         else                      nxt.rails = nxt.rails | R_PROCHOT;
      end

      unique case (cur.state)
         ST_G3: begin
            if (req.power_on_request) begin
               nxt.state = ST_G3S5; nxt.sub_step = '0; nxt.wait_count = '0;
            end
         end
         ST_G3S5: begin
            case (cur.sub_step) inside
               4'd0: begin
                  if (cur.s5_tries != '0) begin
                     nxt.state = ST_S5; nxt.sub_step = '0; nxt.wait_count = '0;
                  end else begin
                     nxt.s5_power_up = 1'b1;
                     nxt.sub_step    = sub_inc;
                     nxt.wait_count  = '0;
                  end
               end
               4'd1, 4'd3, 4'd4, 4'd5, 4'd7, 4'd8: begin
                  if (g3s5_hit) begin
                     nxt.wait_count = '0;
                     nxt.sub_step   = sub_inc;
                     case (cur.sub_step)
                        4'd3: nxt.rails = nxt.rails | R_PWRBTN;
                        4'd4: nxt.rails = nxt.rails | R_DPWROK;
                        4'd7: nxt.rails = nxt.rails | R_RSMRST | R_AC;
                        4'd8: begin
                           nxt.state = ST_S5; nxt.sub_step = '0;
                        end
                        default: ;
                     endcase
                  end else begin
                     nxt.wait_count = wc_inc;
                  end
               end
               4'd2, 4'd6: begin
                  if ((cur.sub_step == 4'd2) ? req.good_3v5v : req.good_aux_vr) begin
                     nxt.wait_count = '0;
                     nxt.sub_step   = sub_inc;
                     if (cur.sub_step == 4'd2) nxt.rails = nxt.rails | R_PCHEN;
                  end else if (pg_fail) begin
                     nxt.rails = nxt.rails & ~R_G3_MASK;
                     fail      = 1'b1;
                     nxt.state = ST_G3; nxt.sub_step = '0; nxt.wait_count = '0;
                  end else begin
                     nxt.wait_count = wc_inc;
                  end
               end
               default: begin
                  nxt.sub_step = '0; nxt.wait_count = '0;
               end
            endcase
         end
         ST_S5: begin
            if (cur.custom_forcing_off) begin
               nxt.state = ST_S5G3; nxt.sub_step = '0; nxt.wait_count = '0;
            end else if (cur.s5_power_up || cfg.s5_wait_always) begin
               if (req.slp_s4_released) begin
                  nxt.s5_tries = '0;
                  nxt.state = ST_S5S3; nxt.sub_step = '0; nxt.wait_count = '0;
               end else if (sec_hit) begin
                  nxt.sub_step = '0; nxt.wait_count = '0;
                  if (give_up) begin
                     led                   = 1'b1;
                     nxt.s5_tries          = '0;
                     ctl.boot_wait_restore = 1'b1;
                     nxt.state             = ST_S5G3;
                  end else begin
                     nxt.s5_tries = try_next[7:0];
                     nxt.state    = ST_G3S5;
                  end
               end else begin
                  nxt.wait_count = wc_inc;
               end
            end else begin
               nxt.s5_tries = '0;
               if (req.slp_s4_released) begin
                  nxt.state = ST_S5S3; nxt.sub_step = '0; nxt.wait_count = '0;
               end
            end
         end
         ST_S5S3: begin
            nxt.rails = nxt.rails | R_SYSON;
            hook      = HK_STARTUP;
            nxt.state = ST_S3; nxt.sub_step = '0; nxt.wait_count = '0;
         end
         ST_S3: begin
            if (req.slp_s3_released) begin
               nxt.state = ST_S3S0; nxt.sub_step = '0; nxt.wait_count = '0;
            end else if (!req.slp_s4_released) begin
               nxt.state = ST_S3S5; nxt.sub_step = '0; nxt.wait_count = '0;
            end
         end
         ST_S3S0: begin
            case (cur.sub_step) inside
               4'd0: begin
                  nxt.rails      = nxt.rails | R_SUSP;
                  nxt.sub_step   = sub_inc;
                  nxt.wait_count = '0;
               end
               4'd1, 4'd2, 4'd4: begin
                  if (s3s0_hit) begin
                     nxt.wait_count = '0;
                     nxt.sub_step   = sub_inc;
                     case (cur.sub_step)
                        4'd1: nxt.rails = nxt.rails | R_VCCST;
                        4'd2: begin
                           nxt.rails = nxt.rails | R_VRON;
                           hook      = HK_RESUME;
                        end
                        default: begin
                           nxt.rails    = nxt.rails | R_SYSPWROK;
                           led          = 1'b1;
                           nxt.state    = ST_S0;
                           nxt.sub_step = '0;
                        end
                     endcase
                  end else begin
                     nxt.wait_count = wc_inc;
                  end
               end
               4'd3: begin
                  if (req.good_core_vr) begin
                     nxt.wait_count = '0;
                     nxt.sub_step   = sub_inc;
                     nxt.rails      = nxt.rails | R_PCHPWROK;
                  end else if (pg_fail) begin
                     nxt.rails = nxt.rails & ~(R_SUSP | R_VCCST | R_VRON);
                     fail      = 1'b1;
                     nxt.state = ST_S3; nxt.sub_step = '0; nxt.wait_count = '0;
                  end else begin
                     nxt.wait_count = wc_inc;
                  end
               end
               default: begin
                  nxt.sub_step = '0; nxt.wait_count = '0;
               end
            endcase
         end
         ST_S0: begin
            if (!req.slp_s3_released) begin
               nxt.rails = nxt.rails & ~(R_VCCST | R_VRON);
               nxt.state = ST_S0S3; nxt.sub_step = '0; nxt.wait_count = '0;
            end
         end
         ST_S0S3: begin
            nxt.rails = nxt.rails & ~(R_SUSP | R_PCHPWROK | R_SYSPWROK);
            hook      = HK_SUSPEND;
            nxt.state = ST_S3; nxt.sub_step = '0; nxt.wait_count = '0;
         end
         ST_S3S5: begin
            nxt.rails       = nxt.rails & ~R_SYSON;
            hook            = HK_SHUTDOWN;
            nxt.s5_power_up = 1'b0;
            nxt.state = ST_S5; nxt.sub_step = '0; nxt.wait_count = '0;
         end
         ST_S5G3: begin
            nxt.custom_forcing_off = 1'b0;
            nxt.rails              = nxt.rails & ~R_G3_MASK;
            nxt.state = ST_G3; nxt.sub_step = '0; nxt.wait_count = '0;
         end
         default: begin
            nxt.state = ST_G3; nxt.sub_step = '0; nxt.wait_count = '0;
         end
      endcase

      res.acpi_state      = state_code(nxt.state);
      res.rail_drive      = nxt.rails;
      res.hook_event      = hook;
      res.release_button  = rel;
      res.led_off         = led;
      res.sequence_failed = fail;
   end

endmodule

`default_nettype wire

### hw/rtl/platform_power_sequencer.sv
// Channel  | Direction | Handshake           | Payload
// req_*    | in        | req_valid/req_stall | ten sampled 1-bit tick inputs
// rsp_*    | out       | rsp_valid/rsp_stall | state, rails, hook, three pulses
// csr_*    | in        | csr_write           | csr_index, csr_data (16 bits)
//
// One item per cycle sustained while rsp_stall is low; each item is captured
// in the input register and is then stepped into the result register.
// Reset (synchronous) puts the sequencer in G3 with all rails low and loads
// register defaults. rsp_stall holds the result register; req_stall rises only
// when both the input and the result register hold an item.
`default_nettype none

module platform_power_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_slp_s3_released,
   input  wire logic                              req_slp_s4_released,
   input  wire logic                              req_slp_sus_released,
   input  wire logic                              req_good_3v5v,
   input  wire logic                              req_good_aux_vr,
   input  wire logic                              req_good_core_vr,
   input  wire logic                              req_power_on_request,
   input  wire logic                              req_force_off_request,
   input  wire logic                              req_espi_reset_seen,
   input  wire logic                              req_throttle_request,
   // result items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [pps_pkg::CODE_W-1:0]             rsp_acpi_state,
   output logic [pps_pkg::RAIL_W-1:0]             rsp_rail_drive,
   output logic [pps_pkg::HOOK_W-1:0]             rsp_hook_event,
   output logic                                   rsp_release_button,
   output logic                                   rsp_led_off,
   output logic                                   rsp_sequence_failed,
   // configuration
   input  wire logic                              csr_write,
   input  wire logic [pps_pkg::CSR_IW-1:0]        csr_index,
   input  wire logic [pps_pkg::CSR_DW-1:0]        csr_data
);
   import pps_pkg::*;

`include "platform_power_sequencer_assert.svh"

   // input register
   logic          in_valid_ff, in_valid_in;
   req_type       in_ff;
   req_type       req_bus;

   // sequencer state
   seq_state_type st_ff, st_nxt;

   // result register
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, step_res;

   cfg_type       cfg;
   csr_ctl_type   step_ctl, csr_ctl;

   logic          accept;
   logic          advance;

   // An item moves to the result side when the result register is empty or
   // being drained this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign req_bus = '{
      slp_s3_released:   req_slp_s3_released,
      slp_s4_released:   req_slp_s4_released,
      slp_sus_released:  req_slp_sus_released,
      good_3v5v:         req_good_3v5v,
      good_aux_vr:       req_good_aux_vr,
      good_core_vr:      req_good_core_vr,
      power_on_request:  req_power_on_request,
      force_off_request: req_force_off_request,
      espi_reset_seen:   req_espi_reset_seen,
      throttle_request:  req_throttle_request
   };

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_bus;
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   // the tick's state update commits together with its result
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.state              <= ST_G3;
         st_ff.sub_step           <= '0;
         st_ff.wait_count         <= '0;
         st_ff.s5_tries           <= '0;
         st_ff.s5_power_up        <= 1'b0;
         st_ff.forcing_off        <= 1'b0;
         st_ff.custom_forcing_off <= 1'b0;
         st_ff.rails              <= '0;
      end else if (advance) begin
         st_ff <= st_nxt;
      end
   end

   pps_step u_step (
      .cur (st_ff),
      .cfg (cfg),
      .req (in_ff),
      .nxt (st_nxt),
      .res (step_res),
      .ctl (step_ctl)
   );

   // retry give-up only takes effect on a committed tick
   assign csr_ctl.boot_wait_restore = advance && step_ctl.boot_wait_restore;

   pps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (csr_ctl),
      .cfg       (cfg)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_acpi_state      = out_ff.acpi_state;
   assign rsp_rail_drive      = out_ff.rail_drive;
   assign rsp_hook_event      = out_ff.hook_event;
   assign rsp_release_button  = out_ff.release_button;
   assign rsp_led_off         = out_ff.led_off;
   assign rsp_sequence_failed = out_ff.sequence_failed;

   // a stall on the input only happens with an item waiting in the input register
   `PPS_CHECK(a_stall_needs_item, req_stall, in_valid_ff)
   // sequencer state only moves with a committed tick
   `PPS_CHECK_NEXT(a_state_holds, !advance, $stable(st_ff))
   // a failed power-good wait always lands in G3 or S3
   `PPS_CHECK(a_fail_target, out_valid_ff && out_ff.sequence_failed,
              out_ff.acpi_state == PS_G3 || out_ff.acpi_state == PS_S3)
   // G3 never reports a driven rail other than pch_en and prochot
   `PPS_CHECK(a_g3_rails_low, out_valid_ff && out_ff.acpi_state == PS_G3,
              (out_ff.rail_drive & R_G3_MASK) == '0)
   // a button release clears the forcing flag
   `PPS_CHECK_NEXT(a_release_clears, advance && step_res.release_button,
                   !st_ff.forcing_off)

endmodule

`default_nettype wire

### tb/sv/power_sequence_check.sv
`timescale 1ns / 100ps

// Watches the tick and result channels plus register writes, runs its own copy
// of the sequencer one tick per accepted item and compares the result items.
module power_sequence_check (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic                         req_slp_s3_released,
   input  wire logic                         req_slp_s4_released,
   input  wire logic                         req_slp_sus_released,
   input  wire logic                         req_good_3v5v,
   input  wire logic                         req_good_aux_vr,
   input  wire logic                         req_good_core_vr,
   input  wire logic                         req_power_on_request,
   input  wire logic                         req_force_off_request,
   input  wire logic                         req_espi_reset_seen,
   input  wire logic                         req_throttle_request,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [pps_pkg::CODE_W-1:0]   rsp_acpi_state,
   input  wire logic [pps_pkg::RAIL_W-1:0]   rsp_rail_drive,
   input  wire logic [pps_pkg::HOOK_W-1:0]   rsp_hook_event,
   input  wire logic                         rsp_release_button,
   input  wire logic                         rsp_led_off,
   input  wire logic                         rsp_sequence_failed,
   input  wire logic                         csr_write,
   input  wire logic [pps_pkg::CSR_IW-1:0]   csr_index,
   input  wire logic [pps_pkg::CSR_DW-1:0]   csr_data,
   output int                                open_count,
   output int                                fail_count,
   output int                                results_seen
);
   import pps_pkg::*;

   // register copies
   logic [7:0]             boot_wait_q;
   logic                   wait_always_q;
   logic [15:0]            pg_limit_q;

   // sequencer copy
   logic [CODE_W-1:0]      mode_q;
   logic [SUB_W-1:0]       step_q;
   logic [COUNT_WIDTH-1:0] ticks_q;
   logic [7:0]             retries_q;
   logic                   booting_q;
   logic                   button_held_q;
   logic                   off_latched_q;
   logic [RAIL_W-1:0]      rails_q;

   rsp_type                tick_outputs_q[$];
   int                     errors = 0;
   int                     checked = 0;

   initial begin
      open_count   = 0;
      fail_count   = 0;
      results_seen = 0;
   end

   function void clear_model();
      boot_wait_q   = BOOT_WAIT_DEFAULT;
      wait_always_q = 1'b0;
      pg_limit_q    = PG_TIMEOUT_DEFAULT;
      mode_q        = PS_G3;
      step_q        = '0;
      ticks_q       = '0;
      retries_q     = '0;
      booting_q     = 1'b0;
      button_held_q = 1'b0;
      off_latched_q = 1'b0;
      rails_q       = '0;
   endfunction

   function void enter_mode(input logic [CODE_W-1:0] m);
      mode_q  = m;
      step_q  = '0;
      ticks_q = '0;
   endfunction

   function void count_tick();
      if (ticks_q != COUNT_MAX)
         ticks_q = ticks_q + 1'b1;
   endfunction

   // fixed wait; moves to the next sub-step when done
   function bit delay_over(input int unsigned n);
      count_tick();
      if (32'(ticks_q) >= n || ticks_q == COUNT_MAX) begin
         ticks_q = '0;
         step_q  = step_q + 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // 1 good, 0 waiting, -1 timed out
   function int pg_result(input logic good);
      if (good) begin
         ticks_q = '0;
         step_q  = step_q + 1'b1;
         return 1;
      end
      count_tick();
      if (32'(ticks_q) >= 32'(pg_limit_q) || ticks_q == COUNT_MAX)
         return -1;
      return 0;
   endfunction

   function automatic rsp_type sequence_tick(input req_type t);
      rsp_type           o;
      logic [HOOK_W-1:0] hook;
      logic              release_pulse;
      logic              led_pulse;
      logic              fail_pulse;
      int                pg;
      logic [8:0]        next_try;
      hook          = HK_NONE;
      release_pulse = 1'b0;
      led_pulse     = 1'b0;
      fail_pulse    = 1'b0;

      // requests see the state at the start of the tick
      if (t.force_off_request && !(mode_q == PS_G3 || mode_q == PS_G3S5 ||
                                   mode_q == PS_S5 || mode_q == PS_S5G3)) begin
         button_held_q = 1'b1;
         off_latched_q = 1'b1;
         rails_q &= ~R_G3_MASK;
      end
      if (t.espi_reset_seen && t.slp_sus_released && button_held_q) begin
         release_pulse = 1'b1;
         button_held_q = 1'b0;
      end
      if (mode_q == PS_S0) begin
         if (t.throttle_request)
            rails_q &= ~R_PROCHOT;
         else
            rails_q |= R_PROCHOT;
      end

      case (mode_q)
         PS_G3: begin
            if (t.power_on_request)
               enter_mode(PS_G3S5);
         end
         PS_G3S5: begin
            case (step_q)
               4'd0: begin
                  if (retries_q != 0) begin
                     enter_mode(PS_S5);
                  end else begin
                     booting_q = 1'b1;
                     step_q    = 4'd1;
                     ticks_q   = '0;
                  end
               end
               4'd1: void'(delay_over(DLY_5));
               4'd2: begin
                  pg = pg_result(t.good_3v5v);
                  if (pg > 0) begin
                     rails_q |= R_PCHEN;
                  end else if (pg < 0) begin
                     rails_q &= ~R_G3_MASK;
                     fail_pulse = 1'b1;
                     enter_mode(PS_G3);
                  end
               end
               4'd3: if (delay_over(DLY_10)) rails_q |= R_PWRBTN;
               4'd4: if (delay_over(DLY_30)) rails_q |= R_DPWROK;
               4'd5: void'(delay_over(DLY_5));
               4'd6: begin
                  pg = pg_result(t.good_aux_vr);
                  if (pg < 0) begin
                     rails_q &= ~R_G3_MASK;
                     fail_pulse = 1'b1;
                     enter_mode(PS_G3);
                  end
               end
               4'd7: if (delay_over(DLY_20)) rails_q |= R_RSMRST | R_AC;
               4'd8: if (delay_over(DLY_50)) enter_mode(PS_S5);
               default: begin
                  step_q  = '0;
                  ticks_q = '0;
               end
            endcase
         end
         PS_S5: begin
            if (off_latched_q) begin
               enter_mode(PS_S5G3);
            end else if (booting_q || wait_always_q) begin
               if (t.slp_s4_released) begin
                  retries_q = '0;
                  enter_mode(PS_S5S3);
               end else begin
                  count_tick();
                  if (32'(ticks_q) >= TICKS_PER_SECOND || ticks_q == COUNT_MAX) begin
                     next_try = {1'b0, retries_q} + 9'd1;
                     ticks_q  = '0;
                     if (next_try > {1'b0, boot_wait_q}) begin
                        // out of retries: give up, restore boot-wait settings
                        led_pulse     = 1'b1;
                        retries_q     = '0;
                        wait_always_q = 1'b0;
                        boot_wait_q   = BOOT_WAIT_DEFAULT;
                        enter_mode(PS_S5G3);
                     end else begin
                        retries_q = next_try[7:0];
                        enter_mode(PS_G3S5);
                     end
                  end
               end
            end else begin
               retries_q = '0;
               if (t.slp_s4_released)
                  enter_mode(PS_S5S3);
            end
         end
         PS_S5S3: begin
            rails_q |= R_SYSON;
            hook = HK_STARTUP;
            enter_mode(PS_S3);
         end
         PS_S3: begin
            if (t.slp_s3_released)
               enter_mode(PS_S3S0);
            else if (!t.slp_s4_released)
               enter_mode(PS_S3S5);
         end
         PS_S3S0: begin
            case (step_q)
               4'd0: begin
                  rails_q |= R_SUSP;
                  step_q  = 4'd1;
                  ticks_q = '0;
               end
               4'd1: if (delay_over(DLY_10)) rails_q |= R_VCCST;
               4'd2: begin
                  if (delay_over(DLY_30)) begin
                     rails_q |= R_VRON;
                     hook = HK_RESUME;
                  end
               end
               4'd3: begin
                  pg = pg_result(t.good_core_vr);
                  if (pg > 0) begin
                     rails_q |= R_PCHPWROK;
                  end else if (pg < 0) begin
                     rails_q &= ~(R_SUSP | R_VCCST | R_VRON);
                     fail_pulse = 1'b1;
                     enter_mode(PS_S3);
                  end
               end
               4'd4: begin
                  if (delay_over(DLY_10)) begin
                     rails_q |= R_SYSPWROK;
                     led_pulse = 1'b1;
                     enter_mode(PS_S0);
                  end
               end
               default: begin
                  step_q  = '0;
                  ticks_q = '0;
               end
            endcase
         end
         PS_S0: begin
            if (!t.slp_s3_released) begin
               rails_q &= ~(R_VCCST | R_VRON);
               enter_mode(PS_S0S3);
            end
         end
         PS_S0S3: begin
            rails_q &= ~(R_SUSP | R_PCHPWROK | R_SYSPWROK);
            hook = HK_SUSPEND;
            enter_mode(PS_S3);
         end
         PS_S3S5: begin
            rails_q &= ~R_SYSON;
            hook = HK_SHUTDOWN;
            booting_q = 1'b0;
            enter_mode(PS_S5);
         end
         PS_S5G3: begin
            off_latched_q = 1'b0;
            rails_q &= ~R_G3_MASK;
            enter_mode(PS_G3);
         end
         default: enter_mode(PS_G3);
      endcase

      o.acpi_state      = mode_q;
      o.rail_drive      = rails_q;
      o.hook_event      = hook;
      o.release_button  = release_pulse;
      o.led_off         = led_pulse;
      o.sequence_failed = fail_pulse;
      return o;
   endfunction

   function void check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      req_type tick_in;
      rsp_type want;
      if (reset) begin
         clear_model();
         tick_outputs_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_BOOT_WAIT:  boot_wait_q   = csr_data[7:0];
               CSR_S5_WAIT:    wait_always_q = csr_data[0];
               CSR_PG_TIMEOUT: pg_limit_q    = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (tick_outputs_q.size() == 0) begin
               $error("result item arrived with no tick outstanding");
               errors++;
            end else begin
               want = tick_outputs_q.pop_front();
               check_field("acpi_state", 16'(want.acpi_state), 16'(rsp_acpi_state));
               check_field("rail_drive", 16'(want.rail_drive), 16'(rsp_rail_drive));
               check_field("hook_event", 16'(want.hook_event), 16'(rsp_hook_event));
               check_field("release_button", 16'(want.release_button),
                           16'(rsp_release_button));
               check_field("led_off", 16'(want.led_off), 16'(rsp_led_off));
               check_field("sequence_failed", 16'(want.sequence_failed),
                           16'(rsp_sequence_failed));
            end
         end
         if (req_valid && !req_stall) begin
            tick_in.slp_s3_released   = req_slp_s3_released;
            tick_in.slp_s4_released   = req_slp_s4_released;
            tick_in.slp_sus_released  = req_slp_sus_released;
            tick_in.good_3v5v         = req_good_3v5v;
            tick_in.good_aux_vr       = req_good_aux_vr;
            tick_in.good_core_vr      = req_good_core_vr;
            tick_in.power_on_request  = req_power_on_request;
            tick_in.force_off_request = req_force_off_request;
            tick_in.espi_reset_seen   = req_espi_reset_seen;
            tick_in.throttle_request  = req_throttle_request;
            tick_outputs_q.push_back(sequence_tick(tick_in));
         end
      end
      open_count   <= tick_outputs_q.size();
      fail_count   <= errors;
      results_seen <= checked;
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

// Top of the sequencer bench. This module only makes traffic: tick items on the
// req_ channel, random stalls on the rsp_ channel and register writes between
// phases. All prediction and comparison lives in power_sequence_check.
module testbench;
   import pps_pkg::*;

   // Input mixes. Each one biases the ten tick inputs so the sequencer is
   // pushed along a particular path rather than dithering in G3.
   typedef enum {
      PRF_NOISE,  // every input a coin flip
      PRF_BOOT,   // power on, rails good, sleep signals released
      PRF_SLEEP,  // SLP_S3 mostly asserted: drops S0 back to S3 and below
      PRF_FAIL,   // power-good inputs mostly low: drives the timeouts
      PRF_HOLD    // SLP_S4 held asserted: parks in S5 for the boot wait
   } tick_profile_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid             = 1'b0;
   logic req_stall;
   logic req_slp_s3_released   = 1'b0;
   logic req_slp_s4_released   = 1'b0;
   logic req_slp_sus_released  = 1'b0;
   logic req_good_3v5v         = 1'b0;
   logic req_good_aux_vr       = 1'b0;
   logic req_good_core_vr      = 1'b0;
   logic req_power_on_request  = 1'b0;
   logic req_force_off_request = 1'b0;
   logic req_espi_reset_seen   = 1'b0;
   logic req_throttle_request  = 1'b0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CODE_W-1:0] rsp_acpi_state;
   logic [RAIL_W-1:0] rsp_rail_drive;
   logic [HOOK_W-1:0] rsp_hook_event;
   logic              rsp_release_button;
   logic              rsp_led_off;
   logic              rsp_sequence_failed;

   logic              csr_write = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data  = '0;

   int open_count;
   int fail_count;
   int results_seen;

   // idle percentages: base values per phase, live values per episode
   int base_send_pct = 0;
   int base_recv_pct = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int sent = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure, re-rolled every cycle. The stall is free to
   // change at any edge; only the block's payload must hold under it.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   platform_power_sequencer dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_slp_s3_released   (req_slp_s3_released),
      .req_slp_s4_released   (req_slp_s4_released),
      .req_slp_sus_released  (req_slp_sus_released),
      .req_good_3v5v         (req_good_3v5v),
      .req_good_aux_vr       (req_good_aux_vr),
      .req_good_core_vr      (req_good_core_vr),
      .req_power_on_request  (req_power_on_request),
      .req_force_off_request (req_force_off_request),
      .req_espi_reset_seen   (req_espi_reset_seen),
      .req_throttle_request  (req_throttle_request),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_acpi_state        (rsp_acpi_state),
      .rsp_rail_drive        (rsp_rail_drive),
      .rsp_hook_event        (rsp_hook_event),
      .rsp_release_button    (rsp_release_button),
      .rsp_led_off           (rsp_led_off),
      .rsp_sequence_failed   (rsp_sequence_failed),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   power_sequence_check checker_i (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_slp_s3_released   (req_slp_s3_released),
      .req_slp_s4_released   (req_slp_s4_released),
      .req_slp_sus_released  (req_slp_sus_released),
      .req_good_3v5v         (req_good_3v5v),
      .req_good_aux_vr       (req_good_aux_vr),
      .req_good_core_vr      (req_good_core_vr),
      .req_power_on_request  (req_power_on_request),
      .req_force_off_request (req_force_off_request),
      .req_espi_reset_seen   (req_espi_reset_seen),
      .req_throttle_request  (req_throttle_request),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_acpi_state        (rsp_acpi_state),
      .rsp_rail_drive        (rsp_rail_drive),
      .rsp_hook_event        (rsp_hook_event),
      .rsp_release_button    (rsp_release_button),
      .rsp_led_off           (rsp_led_off),
      .rsp_sequence_failed   (rsp_sequence_failed),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .open_count            (open_count),
      .fail_count            (fail_count),
      .results_seen          (results_seen)
   );

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Builds one tick item. Percentages are listed in req_type field order:
   // s3, s4, sus, 3v5v, aux, core, power_on, force_off, espi, throttle.
   function automatic req_type roll_tick(input tick_profile_type p);
      int         pct [10];
      logic [9:0] bits;
      case (p)
         PRF_BOOT:  pct = '{90, 95, 50, 97, 97, 97, 20,  1,  5, 50};
         PRF_SLEEP: pct = '{10, 80, 60, 95, 95, 95, 10,  2, 10, 50};
         PRF_FAIL:  pct = '{85, 90, 50, 10, 10, 10, 30,  3, 10, 50};
         PRF_HOLD:  pct = '{50,  0, 50, 97, 97, 97, 50,  0,  0, 50};
         default:   pct = '{50, 50, 50, 50, 50, 50, 50, 50, 50, 50};
      endcase
      // first struct field is the top bit of the packed vector
      for (int i = 0; i < 10; i++)
         bits[9-i] = chance(pct[i]);
      return req_type'(bits);
   endfunction

   // Offers one tick item and returns at the edge where it is taken. Idle
   // cycles are inserted only before the item is offered, so valid never
   // reacts to stall and a stalled payload stays put.
   task automatic send_tick(input req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_slp_s3_released   <= t.slp_s3_released;
      req_slp_s4_released   <= t.slp_s4_released;
      req_slp_sus_released  <= t.slp_sus_released;
      req_good_3v5v         <= t.good_3v5v;
      req_good_aux_vr       <= t.good_aux_vr;
      req_good_core_vr      <= t.good_core_vr;
      req_power_on_request  <= t.power_on_request;
      req_force_off_request <= t.force_off_request;
      req_espi_reset_seen   <= t.espi_reset_seen;
      req_throttle_request  <= t.throttle_request;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent++;
   endtask

   // One stretch of ticks from a single mix. About one stretch in five runs
   // with no idling at all so back-to-back traffic shows up in every phase.
   task automatic run_episode(input tick_profile_type p, input int len);
      if (chance(20)) begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end else begin
         send_idle_pct  = base_send_pct;
         recv_stall_pct = base_recv_pct;
      end
      repeat (len)
         send_tick(roll_tick(p));
   endtask

   // Random mix of stretches; fail_pct weights the power-good failure mix.
   task automatic run_phase(input int n_items, input int fail_pct);
      int done;
      int len;
      int pick;
      tick_profile_type p;
      done = 0;
      while (done < n_items) begin
         pick = $urandom_range(99);
         if (pick < fail_pct)
            p = PRF_FAIL;
         else if (pick < fail_pct + 15)
            p = PRF_NOISE;
         else if (pick < fail_pct + 35)
            p = PRF_SLEEP;
         else
            p = PRF_BOOT;
         len = $urandom_range(120, 10);
         if (len > n_items - done)
            len = n_items - done;
         run_episode(p, len);
         done += len;
      end
   endtask

   // Stops offering items and waits until every result item is back. The
   // checker's count is registered, so the task waits on the clock before reading it.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0)
         @(posedge clock);
      // leave a little margin
      repeat (4) @(posedge clock);
   endtask

   // Registers change only with the block idle.
   task automatic write_regs(input logic [7:0] boot_wait, input logic wait_always,
                             input logic [15:0] pg_timeout);
      drain();
      csr_write <= 1'b1;
      csr_index <= CSR_BOOT_WAIT;
      csr_data  <= {8'd0, boot_wait};
      @(posedge clock);
      csr_index <= CSR_S5_WAIT;
      csr_data  <= {15'd0, wait_always};
      @(posedge clock);
      csr_index <= CSR_PG_TIMEOUT;
      csr_data  <= pg_timeout;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      // receiver mostly stalled, sender idles a third of the time
      base_send_pct  = 33;
      base_recv_pct  = 85;
      send_idle_pct  = 33;
      recv_stall_pct = 85;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed items from G3: all inputs low, all high (power on and a
      // force off that must be ignored in an off state), then each input
      // alone high and alone low.
      send_tick(req_type'(10'h000));
      send_tick(req_type'(10'h3FF));
      for (int i = 0; i < 10; i++)
         send_tick(req_type'(10'h001 << i));
      for (int i = 0; i < 10; i++)
         send_tick(req_type'(~(10'h001 << i)));

      // widest boot wait and the longest power-good timeout
      write_regs(8'd255, 1'b0, 16'd65535);
      run_phase(140, 0);

      // one-tick power-good timeout, no S5 retries allowed
      write_regs(8'd0, 1'b0, 16'd1);
      run_phase(110, 30);

      // sender now the slow side
      base_send_pct = 85;
      base_recv_pct = 33;

      // zero timeout: any low power-good tick fails the step
      write_regs(8'd9, 1'b0, 16'd0);
      run_phase(90, 30);

      // S5 boot wait enabled: park with SLP_S4 asserted so the block sits in
      // S5 counting toward a retry, then let it boot on.
      write_regs(8'd1, 1'b1, 16'd100);
      run_episode(PRF_HOLD, 60);
      run_episode(PRF_BOOT, 40);

      // no idling from here on
      base_send_pct = 0;
      base_recv_pct = 0;

      write_regs(8'd3, 1'b1, 16'd7);
      run_phase(100, 15);

      write_regs(8'd9, 1'b0, 16'd100);
      run_phase(90, 10);

      drain();

      $display("Drove %0d tick items over six register settings, three idle mixes;", sent);
      $display("checked %0d result items incl. power-good timeouts and S5 parking.",
               results_seen);
      if (fail_count == 0 && open_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: the slowest legal run is well under a tenth of this.
   initial begin
      #(5_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pps_pkg.sv
hw/rtl/pps_csr.sv
hw/rtl/pps_step.sv
hw/rtl/platform_power_sequencer.sv
tb/sv/power_sequence_check.sv
tb/sv/testbench.sv
